FILE: rtl/avp_pkg.sv
// Package for the 1-D average pooling stream: sizes, slot and control types,
// and the reciprocal table used by the divider. No dependencies.
`timescale 1ns / 1ps
package avp_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int SUM_BITS    = 20;
	localparam int POS_BITS    = 13;
	localparam int MAX_WINDOW  = 16;
	localparam int MAX_ROW     = 4096;
	localparam int PAD_LIMIT   = 8;
	localparam int OUT_LIMIT   = 24;
	localparam int RECIP_BITS  = 26;
	localparam int RECIP_SHIFT = 25;

	typedef struct packed {
		logic                       open;
		logic [POS_BITS-1:0]        start;
		logic signed [SUM_BITS-1:0] sum;
	} avp_slot_t;

	typedef struct packed {
		logic                          clear;
		logic                          pop;
		logic                          push;
		logic                          add;
		logic [POS_BITS-1:0]           new_start;
		logic [POS_BITS-1:0]           q;
		logic [4:0]                    k;
		logic signed [SAMPLE_BITS-1:0] x;
	} avp_cell_ctl_t;

	// Values are ceil(2^25 / d); a zero divisor maps to zero so the result is zero.
	function automatic logic [RECIP_BITS-1:0] avp_recip(input logic [4:0] d);
		logic [RECIP_BITS-1:0] m;
		case (d)
			5'd1:    m = 26'd33554432;
			5'd2:    m = 26'd16777216;
			5'd3:    m = 26'd11184811;
			5'd4:    m = 26'd8388608;
			5'd5:    m = 26'd6710887;
			5'd6:    m = 26'd5592406;
			5'd7:    m = 26'd4793491;
			5'd8:    m = 26'd4194304;
			5'd9:    m = 26'd3728271;
			5'd10:   m = 26'd3355444;
			5'd11:   m = 26'd3050403;
			5'd12:   m = 26'd2796203;
			5'd13:   m = 26'd2581111;
			5'd14:   m = 26'd2396746;
			5'd15:   m = 26'd2236963;
			5'd16:   m = 26'd2097152;
			default: m = '0;
		endcase
		return m;
	endfunction

endpackage

FILE: rtl/avg_pool_1d_stream.sv
// Streaming 1-D average pooling: a sequencer over a chain of window-slot cells and a
// reciprocal divider. Depends on avp_pkg, avp_cell and avp_div.
// A sample is accepted only while idle; the sequencer then opens each window start and
// closes each finished window; a row end also drains windows still open or pending.
// A result enters the divider once the next result or the sample's end frees the hold
// register; an output stall freezes the sequencer. Reset restores the defaults.
`timescale 1ns / 1ps
module avg_pool_1d_stream (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // sample
	input  logic        s_tlast,   // row_end
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // average
	output logic        m_tlast,   // last_of_row
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [4:0]  cfg_data
);
	import avp_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_CLOSE1 = 3'd1;
	localparam logic [2:0] S_OPEN   = 3'd2;
	localparam logic [2:0] S_ADD    = 3'd3;
	localparam logic [2:0] S_CLOSE2 = 3'd4;
	localparam logic [2:0] S_FIN1   = 3'd5;
	localparam logic [2:0] S_FIN2   = 3'd6;
	localparam logic [2:0] S_DONE   = 3'd7;

	localparam logic [2:0] R_WINDOW = 3'd0;
	localparam logic [2:0] R_STEP   = 3'd1;
	localparam logic [2:0] R_PAD    = 3'd2;
	localparam logic [2:0] R_CEIL   = 3'd3;
	localparam logic [2:0] R_CNTPAD = 3'd4;

	logic [2:0]          state_q;
	logic [4:0]          win_q, step_q;
	logic [3:0]          pad_q;
	logic                ceil_q, cntpad_q;
	logic [POS_BITS-1:0] position_q, ns_q, lim_q;
	logic signed [SAMPLE_BITS-1:0] x_q;
	logic                last_q, partial_q;
	logic [4:0]          cnt_q;
	logic                hold_v_q;
	logic signed [SUM_BITS-1:0] hold_sum_q;
	logic [4:0]          hold_d_q;

	logic [4:0]          k, st;
	logic [3:0]          p;
	avp_slot_t           slot [MAX_WINDOW];
	avp_slot_t           head;
	avp_cell_ctl_t       ctl;
	logic                full, adv;
	logic [POS_BITS:0]   head_end, ns_end, lim14, total14, p14, k14;
	logic                head_close;

	logic                pop, push, add, clr, flush, ns_step, set_partial;
	logic                e_valid, e_keep;
	logic signed [SUM_BITS-1:0] e_sum;
	logic [POS_BITS-1:0] e_s;
	logic [POS_BITS:0]   s14, send, lo, hi, diff;
	logic [4:0]          e_d;
	logic                div_v, div_last;

	assign k  = (win_q == 5'd0) ? 5'd1 : ((win_q > 5'(MAX_WINDOW)) ? 5'(MAX_WINDOW) : win_q);
	assign st = (step_q == 5'd0) ? 5'd1 : step_q;
	assign p  = (pad_q > 4'(PAD_LIMIT)) ? 4'(PAD_LIMIT) : pad_q;

	assign head     = slot[0];
	assign full     = slot[MAX_WINDOW-1].open;
	assign k14      = {{(POS_BITS-4){1'b0}}, k};
	assign p14      = {{(POS_BITS-3){1'b0}}, p};
	assign head_end = {1'b0, head.start} + k14;
	assign ns_end   = {1'b0, ns_q} + k14;
	assign lim14    = {1'b0, lim_q};
	assign total14  = lim14 + p14;
	assign head_close = head.open && (head_end <= lim14);

	always_comb begin
		pop = 1'b0; push = 1'b0; add = 1'b0; clr = 1'b0; flush = 1'b0;
		ns_step = 1'b0; set_partial = 1'b0;
		e_valid = 1'b0; e_sum = head.sum; e_s = head.start;
		case (state_q)
			S_CLOSE1, S_CLOSE2: begin
				if (head_close) begin
					e_valid = 1'b1;
					pop     = 1'b1;
				end
			end
			S_OPEN: begin
				if ({1'b0, ns_q} <= lim14) begin
					ns_step = 1'b1;
					if (ns_end <= lim14) begin
						e_valid = 1'b1;
						e_sum   = '0;
						e_s     = ns_q;
					end else if (!full) begin
						push = 1'b1;
					end
				end
			end
			S_ADD: add = 1'b1;
			S_FIN1: begin
				if (head.open) begin
					pop = 1'b1;
					if (head_end <= total14) begin
						e_valid = 1'b1;
					end else if (!partial_q) begin
						set_partial = 1'b1;
						e_valid     = ceil_q && (head.start < lim_q);
					end
				end
			end
			S_FIN2: begin
				e_sum = '0;
				e_s   = ns_q;
				if (!partial_q && cnt_q < 5'(OUT_LIMIT)) begin
					if (ns_end <= total14) begin
						e_valid = 1'b1;
						ns_step = 1'b1;
					end else begin
						set_partial = 1'b1;
						e_valid     = ceil_q && (ns_q < lim_q);
					end
				end
			end
			S_DONE: begin
				flush = 1'b1;
				clr   = last_q;
			end
			default: ;
		endcase
	end

	always_comb begin
		s14  = {1'b0, e_s};
		send = s14 + k14;
		if (cntpad_q) begin
			lo = s14;
			hi = (send < total14) ? send : total14;
		end else begin
			lo = (s14 > p14) ? s14 : p14;
			hi = (send < lim14) ? send : lim14;
		end
		diff = hi - lo;
		e_d  = (hi > lo) ? diff[4:0] : 5'd0;
	end

	assign e_keep   = e_valid && (cnt_q < 5'(OUT_LIMIT));
	assign div_v    = hold_v_q && (e_keep || flush);
	assign div_last = flush && last_q;

	assign ctl = '{clear: clr && adv, pop: pop && adv, push: push && adv, add: add && adv,
		new_start: ns_q, q: lim_q, k: k, x: x_q};

	genvar gi;
	generate
		for (gi = 0; gi < MAX_WINDOW; gi++) begin : g_cell
			avp_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctl       (ctl),
				.prev_open ((gi == 0) ? 1'b1 : slot[(gi == 0) ? 0 : gi-1].open),
				.next_slot ((gi == MAX_WINDOW-1) ? avp_slot_t'('0)
					: slot[(gi == MAX_WINDOW-1) ? gi : gi+1]),
				.slot      (slot[gi])
			);
		end
	endgenerate

	avp_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (div_v && (state_q != S_IDLE)),
		.in_sum    (hold_sum_q),
		.in_d      (hold_d_q),
		.in_last   (div_last),
		.out_ready (m_tready),
		.adv       (adv),
		.out_valid (m_tvalid),
		.out_avg   (m_tdata),
		.out_last  (m_tlast)
	);

	assign s_tready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			win_q      <= 5'd2;
			step_q     <= 5'd2;
			pad_q      <= 4'd0;
			ceil_q     <= 1'b0;
			cntpad_q   <= 1'b1;
			position_q <= '0;
			ns_q       <= '0;
			lim_q      <= '0;
			x_q        <= '0;
			last_q     <= 1'b0;
			partial_q  <= 1'b0;
			cnt_q      <= '0;
			hold_v_q   <= 1'b0;
			hold_sum_q <= '0;
			hold_d_q   <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					R_WINDOW: win_q    <= cfg_data;
					R_STEP:   step_q   <= cfg_data;
					R_PAD:    pad_q    <= cfg_data[3:0];
					R_CEIL:   ceil_q   <= cfg_data[0];
					R_CNTPAD: cntpad_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (state_q == S_IDLE) begin
				if (s_tvalid) begin
					x_q       <= s_tdata;
					last_q    <= s_tlast;
					cnt_q     <= '0;
					partial_q <= 1'b0;
					lim_q     <= {{(POS_BITS-4){1'b0}}, p} + position_q;
					if (position_q < POS_BITS'(MAX_ROW)) begin
						state_q <= S_CLOSE1;
					end else if (s_tlast) begin
						state_q <= S_FIN1;
					end else begin
						state_q <= S_DONE;
					end
				end
			end else if (adv) begin
				if (e_keep) begin
					cnt_q      <= cnt_q + 5'd1;
					hold_v_q   <= 1'b1;
					hold_sum_q <= e_sum;
					hold_d_q   <= e_d;
				end
				if (ns_step) begin
					ns_q <= ns_q + {{(POS_BITS-5){1'b0}}, st};
				end
				if (set_partial) begin
					partial_q <= 1'b1;
				end
				case (state_q)
					S_CLOSE1: begin
						if (!head_close) state_q <= S_OPEN;
					end
					S_OPEN: begin
						if ({1'b0, ns_q} > lim14) state_q <= S_ADD;
					end
					S_ADD: begin
						lim_q   <= lim_q + 1'b1;
						state_q <= S_CLOSE2;
					end
					S_CLOSE2: begin
						if (!head_close) begin
							position_q <= position_q + 1'b1;
							if (last_q) begin
								lim_q   <= {{(POS_BITS-4){1'b0}}, p} + position_q + 1'b1;
								state_q <= S_FIN1;
							end else begin
								state_q <= S_DONE;
							end
						end
					end
					S_FIN1: begin
						if (!head.open) state_q <= S_FIN2;
					end
					S_FIN2: begin
						if (partial_q || cnt_q >= 5'(OUT_LIMIT)) state_q <= S_DONE;
					end
					S_DONE: begin
						hold_v_q <= 1'b0;
						if (last_q) begin
							position_q <= '0;
							ns_q       <= '0;
						end
						state_q <= S_IDLE;
					end
					default: state_q <= S_IDLE;
				endcase
			end
		end
	end

	a_idle_no_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !hold_v_q)
		else $error("result held while idle");

	a_queue_packed: assert property (@(posedge clk) disable iff (!arst_n)
		!slot[0].open |-> !slot[MAX_WINDOW-1].open)
		else $error("slot queue has a gap at the head");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 5'(OUT_LIMIT))
		else $error("result count exceeds limit");

endmodule

FILE: rtl/avp_cell.sv
// One window slot of the open-window queue; shifts toward the head on a pop.
// Depends on avp_pkg.
`timescale 1ns / 1ps
module avp_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  avp_pkg::avp_cell_ctl_t ctl,
	input  logic                  prev_open,
	input  avp_pkg::avp_slot_t    next_slot,
	output avp_pkg::avp_slot_t    slot
);
	import avp_pkg::*;

	logic                open_q;
	logic [POS_BITS-1:0] start_q;
	logic signed [SUM_BITS-1:0] sum_q;
	logic                load_new;
	logic                covers;
	logic [POS_BITS:0]   win_end;

	assign load_new = ctl.push && !open_q && prev_open;
	assign win_end  = {1'b0, start_q} + {{(POS_BITS-4){1'b0}}, ctl.k};
	assign covers   = open_q && (start_q <= ctl.q) && ({1'b0, ctl.q} < win_end);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
		end else if (ctl.clear) begin
			open_q <= 1'b0;
		end else if (ctl.pop) begin
			open_q <= next_slot.open;
		end else if (load_new) begin
			open_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.pop) begin
			start_q <= next_slot.start;
			sum_q   <= next_slot.sum;
		end else if (load_new) begin
			start_q <= ctl.new_start;
			sum_q   <= '0;
		end else if (ctl.add && covers) begin
			sum_q <= sum_q + {{(SUM_BITS-SAMPLE_BITS){ctl.x[SAMPLE_BITS-1]}}, ctl.x};
		end
	end

	assign slot = '{open: open_q, start: start_q, sum: sum_q};

endmodule

FILE: rtl/avp_div.sv
// Three-stage divider by 1..16 through a reciprocal multiply, with the output register.
// Depends on avp_pkg.
`timescale 1ns / 1ps
module avp_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic signed [avp_pkg::SUM_BITS-1:0] in_sum,
	input  logic [4:0]                        in_d,
	input  logic                              in_last,
	input  logic                              out_ready,
	output logic                              adv,
	output logic                              out_valid,
	output logic [avp_pkg::SAMPLE_BITS-1:0]   out_avg,
	output logic                              out_last
);
	import avp_pkg::*;

	logic                  v_s1, neg_s1, last_s1;
	logic [SUM_BITS-1:0]   mag_s1;
	logic [RECIP_BITS-1:0] m_s1;
	logic                  v_s2, neg_s2, last_s2;
	logic [SUM_BITS+RECIP_BITS-1:0] prod_s2;
	logic [SAMPLE_BITS-1:0] quo;

	assign adv = !out_valid || out_ready;
	assign quo = prod_s2[RECIP_SHIFT+SAMPLE_BITS-1:RECIP_SHIFT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			v_s1      <= in_valid;
			v_s2      <= v_s1;
			out_valid <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			neg_s1   <= in_sum[SUM_BITS-1];
			mag_s1   <= in_sum[SUM_BITS-1] ? SUM_BITS'(-in_sum) : SUM_BITS'(in_sum);
			m_s1     <= avp_recip(in_d);
			last_s1  <= in_last;
			prod_s2  <= {{RECIP_BITS{1'b0}}, mag_s1} * {{SUM_BITS{1'b0}}, m_s1};
			neg_s2   <= neg_s1;
			last_s2  <= last_s1;
			out_avg  <= neg_s2 ? SAMPLE_BITS'(-quo) : quo;
			out_last <= last_s2;
		end
	end

endmodule

FILE: tb/avg_pool_1d_stream_tb.sv
// Self-checking testbench for avg_pool_1d_stream: queued samples are driven with random gaps,
// results are taken with random stalls and checked against an in-bench pooling predictor.
// Depends on avp_pkg and the avg_pool_1d_stream RTL.
`timescale 1ns / 1ps
module avg_pool_1d_stream_tb;
	import avp_pkg::*;

	localparam logic [2:0] REG_WINDOW = 3'd0;
	localparam logic [2:0] REG_STEP   = 3'd1;
	localparam logic [2:0] REG_PAD    = 3'd2;
	localparam logic [2:0] REG_CEIL   = 3'd3;
	localparam logic [2:0] REG_COUNT  = 3'd4;

	typedef struct {
		logic signed [SAMPLE_BITS-1:0] sample;
		logic                          row_end;
	} sample_t;

	typedef struct {
		logic signed [SAMPLE_BITS-1:0] average;
		logic                          last_of_row;
	} average_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic        s_tlast = 0;
	logic        m_tvalid;
	logic        m_tready = 0;
	logic [15:0] m_tdata;
	logic        m_tlast;
	logic        cfg_we = 0;
	logic [2:0]  cfg_index = '0;
	logic [4:0]  cfg_data = '0;

	sample_t  sample_q[$];
	average_t average_q[$];
	int       errors = 0;
	int       gap_left = 0;
	int       stall_left = 0;
	bit       calm = 0;

	// Predictor copy of the configuration and the row state.
	logic [4:0] p_window = 5'd2;
	logic [4:0] p_step = 5'd2;
	logic [3:0] p_pad = 4'd0;
	logic       p_ceil = 0;
	logic       p_count = 1;
	longint     win_sum[MAX_WINDOW];
	int         win_start[MAX_WINDOW];
	bit         win_open[MAX_WINDOW];
	int         row_pos = 0;
	int         start_next = 0;
	int         step_results;

	avg_pool_1d_stream u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	function automatic int eff_k();
		return (p_window == 0) ? 1 : ((p_window > MAX_WINDOW) ? MAX_WINDOW : int'(p_window));
	endfunction

	function automatic int eff_p();
		return (p_pad > PAD_LIMIT) ? PAD_LIMIT : int'(p_pad);
	endfunction

	function automatic int eff_st();
		return (p_step == 0) ? 1 : int'(p_step);
	endfunction

	function automatic int draw_wait();
		return calm ? 0 : $urandom_range(0, 4);
	endfunction

	task automatic push_average(longint sum, int s, int real_end);
		int lo, hi;
		average_t a;
		longint avg;
		if (step_results >= OUT_LIMIT) return;
		if (p_count) begin
			lo = s;
			hi = s + eff_k();
			if (hi > real_end + eff_p()) hi = real_end + eff_p();
		end else begin
			lo = (s > eff_p()) ? s : eff_p();
			hi = s + eff_k();
			if (hi > real_end) hi = real_end;
		end
		avg = (hi > lo) ? sum / longint'(hi - lo) : 0;
		a.average = avg[SAMPLE_BITS-1:0];
		a.last_of_row = 0;
		average_q.push_back(a);
		step_results++;
	endtask

	function automatic int oldest_window();
		int best;
		best = -1;
		for (int i = 0; i < MAX_WINDOW; i++)
			if (win_open[i] && (best < 0 || win_start[i] < win_start[best])) best = i;
		return best;
	endfunction

	task automatic close_windows(int limit);
		int i;
		i = oldest_window();
		while (i >= 0 && win_start[i] + eff_k() <= limit) begin
			push_average(win_sum[i], win_start[i], limit);
			win_open[i] = 0;
			i = oldest_window();
		end
	endtask

	task automatic end_row();
		int real_end, total, s, i;
		bit partial_done;
		real_end = eff_p() + row_pos;
		total = real_end + eff_p();
		partial_done = 0;
		i = oldest_window();
		while (i >= 0) begin
			s = win_start[i];
			win_open[i] = 0;
			if (s + eff_k() <= total) begin
				push_average(win_sum[i], s, real_end);
			end else if (!partial_done) begin
				partial_done = 1;
				if (p_ceil && s < real_end) push_average(win_sum[i], s, real_end);
			end
			i = oldest_window();
		end
		while (!partial_done && step_results < OUT_LIMIT) begin
			s = start_next;
			if (s + eff_k() <= total) begin
				push_average(0, s, real_end);
				start_next += eff_st();
			end else begin
				partial_done = 1;
				if (p_ceil && s < real_end) push_average(0, s, real_end);
			end
		end
		if (step_results > 0) average_q[$].last_of_row = 1;
		for (int j = 0; j < MAX_WINDOW; j++) begin
			win_open[j] = 0;
			win_sum[j] = 0;
			win_start[j] = 0;
		end
		row_pos = 0;
		start_next = 0;
	endtask

	task automatic predict_sample(sample_t it);
		int q, slot;
		step_results = 0;
		if (row_pos < MAX_ROW) begin
			q = eff_p() + row_pos;
			close_windows(q);
			while (start_next <= q) begin
				if (start_next + eff_k() <= q) begin
					push_average(0, start_next, q);
				end else begin
					slot = -1;
					for (int i = MAX_WINDOW - 1; i >= 0; i--)
						if (!win_open[i]) slot = i;
					if (slot >= 0) begin
						win_open[slot] = 1;
						win_start[slot] = start_next;
						win_sum[slot] = 0;
					end
				end
				start_next += eff_st();
			end
			for (int i = 0; i < MAX_WINDOW; i++)
				if (win_open[i] && win_start[i] <= q && q < win_start[i] + eff_k())
					win_sum[i] += longint'(it.sample);
			close_windows(q + 1);
			row_pos++;
		end
		if (it.row_end) end_row();
	endtask

	task automatic report(string field, logic [15:0] got, logic [15:0] want);
		$display("mismatch on %s: got %0d, expected %0d at %0t", field, $signed(got),
			$signed(want), $realtime);
		errors++;
	endtask

	// Driver: holds a transaction until accepted, then idles for a drawn gap.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 0;
			gap_left <= 0;
		end else if (s_tvalid && !s_tready) begin
		end else begin
			if (s_tvalid && s_tready) predict_sample('{s_tdata, s_tlast});
			if (gap_left > 0 && !(s_tvalid && s_tready)) begin
				s_tvalid <= 0;
				gap_left <= gap_left - 1;
			end else if (s_tvalid && s_tready && gap_left > 0) begin
				s_tvalid <= 0;
				gap_left <= gap_left - 1;
			end else if (sample_q.size() > 0) begin
				sample_t it;
				it = sample_q.pop_front();
				s_tvalid <= 1;
				s_tdata <= it.sample;
				s_tlast <= it.row_end;
				gap_left <= draw_wait();
			end else begin
				s_tvalid <= 0;
			end
		end
	end

	// Monitor: checks each result transaction and stalls for a drawn number of cycles.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 0;
			stall_left <= 0;
		end else if (m_tvalid && m_tready) begin
			int n;
			if (average_q.size() == 0) begin
				$display("unexpected result %0d at %0t", $signed(m_tdata), $realtime);
				errors++;
			end else begin
				average_t a;
				a = average_q.pop_front();
				if (m_tdata !== a.average) report("average", m_tdata, a.average);
				if (m_tlast !== a.last_of_row) report("last_of_row", m_tlast, a.last_of_row);
			end
			n = draw_wait();
			stall_left <= n;
			m_tready <= (n == 0);
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready <= (stall_left == 1);
		end else begin
			m_tready <= 1;
		end
	end

	function automatic logic [15:0] pick_sample();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			default: return 16'($urandom());
		endcase
	endfunction

	task automatic queue_row(int len);
		for (int i = 0; i < len; i++) sample_q.push_back('{pick_sample(), i == len - 1});
	endtask

	task automatic wait_idle();
		while (sample_q.size() > 0 || s_tvalid || average_q.size() > 0) @(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	task automatic configure(logic [4:0] w, logic [4:0] st, logic [3:0] pd, logic c, logic cnt);
		logic [2:0] idx[5];
		logic [4:0] val[5];
		idx = '{REG_WINDOW, REG_STEP, REG_PAD, REG_CEIL, REG_COUNT};
		val = '{w, st, 5'(pd), 5'(c), 5'(cnt)};
		for (int i = 0; i < 5; i++) begin
			@(posedge clk);
			cfg_we <= 1;
			cfg_index <= idx[i];
			cfg_data <= val[i];
		end
		@(posedge clk);
		cfg_we <= 0;
		p_window = w;
		p_step = st;
		p_pad = pd;
		p_ceil = c;
		p_count = cnt;
	endtask

	initial begin
		int sent;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		repeat (3) @(posedge clk);

		// Directed: reset settings, extremes, short rows, zero and oversized settings.
		sample_q.push_back('{16'sh7fff, 1'b0});
		sample_q.push_back('{16'sh7fff, 1'b0});
		sample_q.push_back('{-16'sh8000, 1'b0});
		sample_q.push_back('{-16'sh8000, 1'b1});
		wait_idle();
		configure(5'd16, 5'd16, 4'd8, 1'b1, 1'b0);
		queue_row(3);
		wait_idle();
		configure(5'd4, 5'd1, 4'd0, 1'b0, 1'b1);
		queue_row(2);
		queue_row(5);
		wait_idle();
		configure(5'd0, 5'd0, 4'd15, 1'b1, 1'b1);
		queue_row(3);
		wait_idle();
		configure(5'd31, 5'd3, 4'd2, 1'b1, 1'b0);
		queue_row(6);
		wait_idle();
		configure(5'd3, 5'd1, 4'd1, 1'b0, 1'b0);
		sample_q.push_back('{16'sh0001, 1'b0});
		sample_q.push_back('{16'sh0005, 1'b0});
		sample_q.push_back('{16'sh0007, 1'b1});
		wait_idle();

		// Random phases.
		sent = 0;
		while (sent < 240) begin
			calm = ($urandom_range(0, 3) == 0);
			configure(5'($urandom_range(0, 31)), 5'($urandom_range(0, 20)),
				4'($urandom_range(0, 15)), 1'($urandom()), 1'($urandom()));
			for (int r = 0; r < 3; r++) begin
				int len;
				len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 24);
				queue_row(len);
				sent += len;
			end
			wait_idle();
		end

		// Wide padding on a short row.
		calm = 0;
		configure(5'd1, 5'd1, 4'd8, 1'b1, 1'b1);
		queue_row(2);
		wait_idle();

		if (errors == 0) begin
			$display("avg_pool_1d_stream: match");
		end else begin
			$display("avg_pool_1d_stream: mismatch");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("avg_pool_1d_stream: mismatch");
		$finish;
	end

endmodule

FILE: sim.f
rtl/avp_pkg.sv
rtl/avp_cell.sv
rtl/avp_div.sv
rtl/avg_pool_1d_stream.sv
tb/avg_pool_1d_stream_tb.sv
